// ===== design/a2d_pkg.sv =====
// Package: shared types and constants of the 2D affine transform engine.
`default_nettype none
package a2d_pkg;

  typedef enum logic [2:0] {
    FUNC_IDENTITY  = 3'd0,
    FUNC_SCALE     = 3'd1,
    FUNC_TRANSLATE = 3'd2,
    FUNC_ROTATE    = 3'd3,
    FUNC_POINT     = 3'd4,
    FUNC_SCALAR    = 3'd5,
    FUNC_RSVD6     = 3'd6,
    FUNC_RSVD7     = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MAC,
    ST_SCALAR,
    ST_OUT
  } state_e;

  localparam int unsigned AtanCount  = 24;
  localparam int unsigned CordicFrac = 30;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  // Command from controller to datapath.
  typedef struct packed {
    logic       load;       // capture item, build elementary matrix input
    logic       ident;      // set matrix to identity
    logic       cordic_step;
    logic       elem_rot;   // load rotation elementary matrix
    logic       mac_step;   // one product and accumulate
    logic       scal_step;  // scale one entry
    logic       commit;     // copy temporary matrix into current
    logic       clr_flag;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic last_cordic;
    logic last_mac;
    logic last_scal;
  } sts_t;

  // Arctangent table in units of 2^-32 turn.
  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340247;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // Saturate a 66-bit signed value to 32 bits.
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sh0_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
    else if (v < -66'sh0_8000_0000) r = {1'b1, 32'h8000_0000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/affine_2d_transform_engine.sv =====
// Top level of the 2D affine transform engine.
// Holds a 3x3 Q16.16 matrix (identity after reset) and applies one operation per
// transfer. One shared multiplier does one product per cycle: scale, translate and
// rotate do 27 MACs, rotate after the CORDIC iteration; transform point does 9 MACs
// plus the result transfer, scalar multiply 9 products, identity none.
// The CORDIC iteration and the single multiply-accumulate unit set the run time.
`default_nettype none
module affine_2d_transform_engine #(
  parameter int unsigned FRAC_BITS    = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  [2:0]         func_i,
  input  wire  signed [31:0] arg_x_i,
  input  wire  signed [31:0] arg_y_i,
  input  wire  signed [31:0] arg_w_i,
  input  wire  [15:0]        turn_angle_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_w_o,
  output logic               overflow_flag_o
);

  a2d_pkg::cmd_t cmd;
  a2d_pkg::sts_t sts;

  a2d_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i,
    .out_valid_o, .out_stall_i, .sts_i(sts), .cmd_o(cmd)
  );

  a2d_datapath #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .func_i, .arg_x_i, .arg_y_i,
    .arg_w_i, .turn_angle_i, .out_x_o, .out_y_o, .out_w_o, .overflow_flag_o
  );

endmodule
`default_nettype wire

// ===== design/a2d_ctrl.sv =====
// Controller: sequences CORDIC steps, multiply-accumulates and the result transfer.
`default_nettype none
module a2d_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_stall_o,
  input  wire  [2:0]      func_i,
  output logic            out_valid_o,
  input  wire             out_stall_i,
  input  a2d_pkg::sts_t   sts_i,
  output a2d_pkg::cmd_t   cmd_o
);

  a2d_pkg::state_e state_q, state_d;
  logic [2:0] func_q;
  logic       acc;

  assign acc = in_valid_i && !in_stall_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      a2d_pkg::ST_IDLE: begin
        if (acc) begin
          case (func_i)
            a2d_pkg::FUNC_SCALE, a2d_pkg::FUNC_TRANSLATE,
            a2d_pkg::FUNC_POINT: state_d = a2d_pkg::ST_MAC;
            a2d_pkg::FUNC_ROTATE: state_d = a2d_pkg::ST_CORDIC;
            a2d_pkg::FUNC_SCALAR: state_d = a2d_pkg::ST_SCALAR;
            default: state_d = a2d_pkg::ST_IDLE;
          endcase
        end
      end
      a2d_pkg::ST_CORDIC: if (sts_i.last_cordic) state_d = a2d_pkg::ST_MAC;
      a2d_pkg::ST_MAC: begin
        if (sts_i.last_mac) begin
          state_d = (func_q == a2d_pkg::FUNC_POINT) ? a2d_pkg::ST_OUT : a2d_pkg::ST_IDLE;
        end
      end
      a2d_pkg::ST_SCALAR: if (sts_i.last_scal) state_d = a2d_pkg::ST_IDLE;
      a2d_pkg::ST_OUT: if (!out_stall_i) state_d = a2d_pkg::ST_IDLE;
      default: state_d = a2d_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      a2d_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load    = acc;
        cmd_o.ident   = acc && (func_i == a2d_pkg::FUNC_IDENTITY);
        cmd_o.clr_flag = acc;
      end
      a2d_pkg::ST_CORDIC: begin
        // Run every step, then load the rotation once the last one has settled.
        cmd_o.cordic_step = !sts_i.last_cordic;
        cmd_o.elem_rot    = sts_i.last_cordic;
      end
      a2d_pkg::ST_MAC: begin
        cmd_o.mac_step = 1'b1;
        cmd_o.commit   = sts_i.last_mac && (func_q != a2d_pkg::FUNC_POINT);
      end
      a2d_pkg::ST_SCALAR: cmd_o.scal_step = 1'b1;
      a2d_pkg::ST_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // Hold state and the operation code.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= a2d_pkg::ST_IDLE;
      func_q  <= 3'd0;
    end else begin
      state_q <= state_d;
      if (acc) func_q <= func_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/a2d_datapath.sv =====
// Datapath: matrix store, CORDIC iteration and one shared multiply-accumulate unit.
`default_nettype none
module a2d_datapath #(
  parameter int unsigned FRAC_BITS    = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  a2d_pkg::cmd_t      cmd_i,
  output a2d_pkg::sts_t      sts_o,
  input  wire  [2:0]         func_i,
  input  wire  signed [31:0] arg_x_i,
  input  wire  signed [31:0] arg_y_i,
  input  wire  signed [31:0] arg_w_i,
  input  wire  [15:0]        turn_angle_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_w_o,
  output logic               overflow_flag_o
);

  localparam int unsigned Steps = (CORDIC_STEPS < a2d_pkg::AtanCount) ?
                                  CORDIC_STEPS : a2d_pkg::AtanCount;
  localparam logic signed [31:0] OneFx = 32'sd1 <<< FRAC_BITS;
  localparam int unsigned CSh = a2d_pkg::CordicFrac - FRAC_BITS;

  logic signed [31:0] m_q [9];
  logic signed [31:0] e_q [9];
  logic signed [31:0] t_q [9];
  logic [2:0]  func_q;
  logic signed [31:0] ax_q, ay_q, aw_q;
  logic [1:0]  quad_q;

  // CORDIC registers.
  logic signed [33:0] cx_q, cy_q;
  logic signed [33:0] cz_q;
  logic [4:0]  ci_q;

  // MAC sequencing: row i, column j, term k.
  logic [1:0]  mi_q, mj_q, mk_q;
  logic [3:0]  si_q;
  logic signed [65:0] acc_q;
  logic        ov_q;

  // Map a 2-bit row and column index to a matrix position.
  function automatic logic [3:0] pos(input logic [1:0] r, input logic [1:0] c);
    return 4'(r) * 4'd3 + 4'(c);
  endfunction

  // Rounded, saturated fixed point product.
  function automatic logic [32:0] fxmul(input logic signed [31:0] a,
                                        input logic signed [31:0] b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b);
    p = (p + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return a2d_pkg::sat32(p);
  endfunction

  logic signed [31:0] opa, opb;
  logic [32:0] prod;
  logic signed [65:0] acc_n;
  logic [32:0] accs;
  logic last_k;
  logic signed [33:0] dx, dy;
  logic signed [33:0] rcx, rcy;
  logic signed [31:0] cc, ss;

  // Select operands of the shared multiplier.
  always_comb begin
    if (cmd_i.scal_step) begin
      opa = m_q[si_q];
      opb = ax_q;
    end else if (func_q == a2d_pkg::FUNC_POINT) begin
      opa = m_q[pos(mi_q, mk_q)];
      opb = (mk_q == 2'd0) ? ax_q : (mk_q == 2'd1) ? ay_q : aw_q;
    end else begin
      opa = e_q[pos(mi_q, mk_q)];
      opb = m_q[pos(mk_q, mj_q)];
    end
    prod   = fxmul(opa, opb);
    last_k = (mk_q == 2'd2);
    acc_n  = acc_q + 66'(signed'(prod[31:0]));
    accs   = a2d_pkg::sat32(acc_n);
  end

  assign sts_o.last_mac = last_k && (mi_q == 2'd2) &&
                          ((func_q == a2d_pkg::FUNC_POINT) || (mj_q == 2'd2));
  assign sts_o.last_scal   = (si_q == 4'd8);
  assign sts_o.last_cordic = (ci_q == 5'(Steps));

  // CORDIC step and final rounding.
  always_comb begin
    dx  = cy_q >>> ci_q;
    dy  = cx_q >>> ci_q;
    rcx = (cx_q + (34'sd1 <<< (CSh - 1))) >>> CSh;
    rcy = (cy_q + (34'sd1 <<< (CSh - 1))) >>> CSh;
    case (quad_q)
      2'd0: begin cc = rcx[31:0];  ss = rcy[31:0];  end
      2'd1: begin cc = -rcy[31:0]; ss = rcx[31:0];  end
      2'd2: begin cc = -rcx[31:0]; ss = -rcy[31:0]; end
      default: begin cc = rcy[31:0]; ss = -rcx[31:0]; end
    endcase
  end

  // Matrix store and sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) m_q[i] <= (i % 4 == 0) ? OneFx : 32'sd0;
      mi_q <= '0; mj_q <= '0; mk_q <= '0; si_q <= '0; ci_q <= '0;
      acc_q <= '0; ov_q <= 1'b0; overflow_flag_o <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        func_q <= func_i;
        ax_q <= arg_x_i; ay_q <= arg_y_i; aw_q <= arg_w_i;
        quad_q <= turn_angle_i[15:14];
        cx_q <= a2d_pkg::CordicGain;
        cy_q <= '0;
        cz_q <= 34'(turn_angle_i[13:0]) <<< 16;
        ci_q <= '0; mi_q <= '0; mj_q <= '0; mk_q <= '0; si_q <= '0;
        acc_q <= '0;
        for (int i = 0; i < 9; i++) e_q[i] <= (i % 4 == 0) ? OneFx : 32'sd0;
        if (func_i == a2d_pkg::FUNC_SCALE) begin
          e_q[0] <= arg_x_i; e_q[4] <= arg_y_i;
        end
        if (func_i == a2d_pkg::FUNC_TRANSLATE) begin
          e_q[2] <= arg_x_i; e_q[5] <= arg_y_i;
        end
      end
      if (cmd_i.clr_flag) ov_q <= 1'b0;
      if (cmd_i.ident) begin
        for (int i = 0; i < 9; i++) m_q[i] <= (i % 4 == 0) ? OneFx : 32'sd0;
      end
      // Advance the CORDIC.
      if (cmd_i.cordic_step) begin
        if (!cz_q[33]) begin
          cx_q <= cx_q - dx; cy_q <= cy_q + dy;
          cz_q <= cz_q - 34'(a2d_pkg::atan_turn(ci_q));
        end else begin
          cx_q <= cx_q + dx; cy_q <= cy_q - dy;
          cz_q <= cz_q + 34'(a2d_pkg::atan_turn(ci_q));
        end
        ci_q <= ci_q + 5'd1;
      end
      if (cmd_i.elem_rot) begin
        e_q[0] <= cc; e_q[1] <= -ss; e_q[3] <= ss; e_q[4] <= cc;
      end
      // Accumulate one product.
      if (cmd_i.mac_step) begin
        ov_q <= ov_q | prod[32] | (last_k & accs[32]);
        if (last_k) begin
          acc_q <= '0;
          mk_q  <= '0;
          if (func_q == a2d_pkg::FUNC_POINT) begin
            case (mi_q)
              2'd0: out_x_o <= accs[31:0];
              2'd1: out_y_o <= accs[31:0];
              default: out_w_o <= accs[31:0];
            endcase
            mi_q <= mi_q + 2'd1;
            if (mi_q == 2'd2) overflow_flag_o <= ov_q | prod[32] | accs[32];
          end else begin
            t_q[pos(mi_q, mj_q)] <= accs[31:0];
            if (mj_q == 2'd2) begin
              mj_q <= '0; mi_q <= mi_q + 2'd1;
            end else begin
              mj_q <= mj_q + 2'd1;
            end
          end
        end else begin
          acc_q <= acc_n;
          mk_q  <= mk_q + 2'd1;
        end
      end
      // Copy the product matrix back, taking the final entry directly.
      if (cmd_i.commit) begin
        for (int i = 0; i < 8; i++) m_q[i] <= t_q[i];
        m_q[8] <= accs[31:0];
      end
      if (cmd_i.scal_step) begin
        m_q[si_q] <= prod[31:0];
        si_q <= si_q + 4'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_affine_2d_transform_engine.sv =====
// Testbench of the 2D affine transform engine: driven items, scoreboard and checks.
`timescale 1ns / 100ps
`default_nettype none

// Expected transformed point.
typedef struct {
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [31:0] pw;
  logic               ovf;
} point_t;

class point_scoreboard;
  logic signed [31:0] mat [9];
  point_t             pending_points [$];
  int                 errors;
  int                 checked;

  function new();
    set_identity();
    errors  = 0;
    checked = 0;
  endfunction

  function void set_identity();
    for (int i = 0; i < 9; i++) mat[i] = (i % 4 == 0) ? 32'sh0001_0000 : 32'sh0;
  endfunction

  // Round a signed value to nearest: add half, then shift arithmetically.
  function logic signed [65:0] round_q(input logic signed [65:0] v, input int k);
    logic signed [65:0] t;
    t = v + (66'sd1 <<< (k - 1));
    return t >>> k;
  endfunction

  function logic signed [31:0] clamp(input logic signed [65:0] v, inout logic ov);
    if (v > 66'sd2147483647) begin
      ov = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -66'sd2147483648) begin
      ov = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function logic signed [31:0] qmul(input logic signed [31:0] a,
                                    input logic signed [31:0] b, inout logic ov);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b);
    return clamp(round_q(p, 16), ov);
  endfunction

  function void premul(input logic signed [31:0] e [9]);
    logic signed [31:0] t [9];
    logic signed [65:0] acc;
    logic               ov;
    ov = 1'b0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += 66'(qmul(e[i*3+k], mat[k*3+j], ov));
        t[i*3+j] = clamp(acc, ov);
      end
    mat = t;
  endfunction

  function void cos_sin(input logic [15:0] ang, output logic signed [31:0] c,
                        output logic signed [31:0] s);
    logic signed [65:0] x, y, z, dx, dy, cx, sy;
    logic [29:0] atan_tab [16];
    atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                 10679838, 5340247, 2670163, 1335087, 667544, 333772, 166886,
                 83443, 41722, 20861};
    z = 66'(ang[13:0]) <<< 16;
    x = 66'sd652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= 66'(atan_tab[i]);
      end else begin
        x += dx; y -= dy; z += 66'(atan_tab[i]);
      end
    end
    cx = round_q(x, 14);
    sy = round_q(y, 14);
    case (ang[15:14])
      2'd0: begin c = cx[31:0];    s = sy[31:0];    end
      2'd1: begin c = -sy[31:0];   s = cx[31:0];    end
      2'd2: begin c = -cx[31:0];   s = -sy[31:0];   end
      default: begin c = sy[31:0]; s = -cx[31:0];   end
    endcase
  endfunction

  // Note one accepted command and update the shadow matrix.
  function void note_command(input a2d_pkg::func_e f, input logic signed [31:0] ax,
                             input logic signed [31:0] ay, input logic signed [31:0] aw,
                             input logic [15:0] ang);
    logic signed [31:0] e [9];
    logic signed [31:0] p [3];
    logic signed [31:0] r [3];
    logic signed [31:0] c, s;
    logic signed [65:0] acc;
    logic               ov;
    point_t             pt;
    ov = 1'b0;
    for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? 32'sh0001_0000 : 32'sh0;
    case (f)
      a2d_pkg::FUNC_IDENTITY: set_identity();
      a2d_pkg::FUNC_SCALE: begin
        e[0] = ax; e[4] = ay; premul(e);
      end
      a2d_pkg::FUNC_TRANSLATE: begin
        e[2] = ax; e[5] = ay; premul(e);
      end
      a2d_pkg::FUNC_ROTATE: begin
        cos_sin(ang, c, s);
        e[0] = c; e[1] = -s; e[3] = s; e[4] = c; premul(e);
      end
      a2d_pkg::FUNC_POINT: begin
        p = '{ax, ay, aw};
        for (int i = 0; i < 3; i++) begin
          acc = 0;
          for (int j = 0; j < 3; j++) acc += 66'(qmul(mat[i*3+j], p[j], ov));
          r[i] = clamp(acc, ov);
        end
        pt.px = r[0]; pt.py = r[1]; pt.pw = r[2]; pt.ovf = ov;
        pending_points.push_back(pt);
      end
      a2d_pkg::FUNC_SCALAR:
        for (int i = 0; i < 9; i++) mat[i] = qmul(mat[i], ax, ov);
      default: ;
    endcase
  endfunction

  task report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  // Compare one transferred result with the oldest expected point.
  task check_point(input logic signed [31:0] ox, input logic signed [31:0] oy,
                   input logic signed [31:0] ow, input logic of);
    point_t pt;
    if (pending_points.size() == 0) begin
      report("unexpected result out_x", ox, 32'h0);
      return;
    end
    pt = pending_points.pop_front();
    checked++;
    if (ox !== pt.px) report("out_x", ox, pt.px);
    if (oy !== pt.py) report("out_y", oy, pt.py);
    if (ow !== pt.pw) report("out_w", ow, pt.pw);
    if (of !== pt.ovf) report("overflow_flag", 32'(of), 32'(pt.ovf));
  endtask
endclass

module tb_affine_2d_transform_engine;

  localparam int CycleLimit = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         func_i = '0;
  logic signed [31:0] arg_x_i = '0;
  logic signed [31:0] arg_y_i = '0;
  logic signed [31:0] arg_w_i = '0;
  logic [15:0]        turn_angle_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] out_x_o, out_y_o, out_w_o;
  logic               overflow_flag_o;

  point_scoreboard sb = new();
  int  cycles = 0;
  int  hold_off = 0;
  bit  long_hold_done = 1'b0;
  int  sent = 0;

  affine_2d_transform_engine i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i, .arg_x_i, .arg_y_i,
    .arg_w_i, .turn_angle_i, .out_valid_o, .out_stall_i, .out_x_o, .out_y_o,
    .out_w_o, .overflow_flag_o
  );

  always #10 clk_i = ~clk_i;

  // Count cycles and stop a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Check results on each output transfer.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_point(out_x_o, out_y_o, out_w_o, overflow_flag_o);
  end

  // Stall the output on a pattern of its own, with one long hold-off.
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off    <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else if (!long_hold_done && sent > 300) begin
      long_hold_done <= 1'b1;
      hold_off       <= 600;
      out_stall_i    <= 1'b1;
    end else if (cycles % 2000 < 500) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  // Offer one command and hold it until transferred.
  task automatic send_cmd(input a2d_pkg::func_e f, input logic [31:0] ax,
                          input logic [31:0] ay, input logic [31:0] aw,
                          input logic [15:0] ang);
    in_valid_i   <= 1'b1;
    func_i       <= f;
    arg_x_i      <= ax;
    arg_y_i      <= ay;
    arg_w_i      <= aw;
    turn_angle_i <= ang;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_command(f, ax, ay, aw, ang);
    sent++;
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Arguments near unity with occasional extreme values.
  function automatic logic [31:0] rand_arg();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 262143)) - 131072);
    endcase
  endfunction

  task automatic send_random();
    a2d_pkg::func_e f;
    int             r;
    r = $urandom_range(0, 99);
    if (r < 8) f = a2d_pkg::FUNC_IDENTITY;
    else if (r < 20) f = a2d_pkg::FUNC_SCALE;
    else if (r < 32) f = a2d_pkg::FUNC_TRANSLATE;
    else if (r < 46) f = a2d_pkg::FUNC_ROTATE;
    else if (r < 90) f = a2d_pkg::FUNC_POINT;
    else if (r < 96) f = a2d_pkg::FUNC_SCALAR;
    else f = a2d_pkg::func_e'($urandom_range(6, 7));
    send_cmd(f, rand_arg(), rand_arg(), rand_arg(), 16'($urandom()));
  endtask

  initial begin
    int burst;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every operation, field extremes, reserved codes.
    send_cmd(a2d_pkg::FUNC_POINT, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 16'h0);
    send_cmd(a2d_pkg::FUNC_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF);
    send_cmd(a2d_pkg::FUNC_ROTATE, 32'h0, 32'h0, 32'h0, 16'h0000);
    send_cmd(a2d_pkg::FUNC_POINT, 32'h0001_0000, 32'h0, 32'h0001_0000, 16'h0);
    send_cmd(a2d_pkg::FUNC_ROTATE, 32'h0, 32'h0, 32'h0, 16'h4000);
    send_cmd(a2d_pkg::FUNC_ROTATE, 32'h0, 32'h0, 32'h0, 16'h8000);
    send_cmd(a2d_pkg::FUNC_ROTATE, 32'h0, 32'h0, 32'h0, 16'hFFFF);
    send_cmd(a2d_pkg::FUNC_POINT, 32'h0003_0000, 32'hFFFE_0000, 32'h0001_0000, 16'h0);
    send_cmd(a2d_pkg::FUNC_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'h0);
    send_cmd(a2d_pkg::FUNC_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0);
    send_cmd(a2d_pkg::FUNC_IDENTITY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             16'hFFFF);
    send_cmd(a2d_pkg::FUNC_TRANSLATE, 32'h0005_8000, 32'hFFFF_0000, 32'h0, 16'h0);
    send_cmd(a2d_pkg::FUNC_POINT, 32'h0, 32'h0, 32'h0001_0000, 16'h0);
    send_cmd(a2d_pkg::FUNC_SCALAR, 32'h8000_0000, 32'h0, 32'h0, 16'h0);
    send_cmd(a2d_pkg::FUNC_POINT, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'h0);
    send_cmd(a2d_pkg::FUNC_RSVD6, 32'h1234_5678, 32'h0, 32'h0, 16'h0);
    send_cmd(a2d_pkg::FUNC_RSVD7, 32'h0, 32'h1234_5678, 32'h0, 16'h0);
    send_cmd(a2d_pkg::FUNC_POINT, 32'h0000_8000, 32'hFFFF_8000, 32'h0, 16'h0);
    send_cmd(a2d_pkg::FUNC_IDENTITY, 32'h0, 32'h0, 32'h0, 16'h0);
    send_cmd(a2d_pkg::FUNC_SCALAR, 32'h0000_0000, 32'h0, 32'h0, 16'h0);
    send_cmd(a2d_pkg::FUNC_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0);
    send_cmd(a2d_pkg::FUNC_IDENTITY, 32'h0, 32'h0, 32'h0, 16'h0);

    // Random bursts with gaps; reset the matrix now and then to keep it tame.
    while (sent < 1000) begin
      burst = $urandom_range(1, 20);
      repeat (burst) send_random();
      if ($urandom_range(0, 3) == 0)
        send_cmd(a2d_pkg::FUNC_IDENTITY, 32'h0, 32'h0, 32'h0, 16'h0);
      if (sent > 600 && sent < 640) begin
        // Pause until every expected point has come back.
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (sb.pending_points.size() != 0) @(posedge clk_i);
      end else begin
        idle_cycles($urandom_range(0, 40));
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending_points.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("covered %0d commands of all codes, %0d transformed points checked",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending_points.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

`default_nettype wire

// ===== filelist.f =====
design/a2d_pkg.sv
design/a2d_ctrl.sv
design/a2d_datapath.sv
design/affine_2d_transform_engine.sv
tb/sv/tb_affine_2d_transform_engine.sv
